FILE: hdl/lattice_aggregation_walk_step_macros.svh
`ifndef LATTICE_AGGREGATION_WALK_STEP_MACROS_SVH
`define LATTICE_AGGREGATION_WALK_STEP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LAGW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LAGW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/lagw_pkg.sv
package lagw_pkg;

  typedef struct packed {
    logic [15:0] thresh_neg_x;
    logic [15:0] thresh_pos_x;
    logic [15:0] thresh_neg_y;
    logic [15:0] thresh_pos_y;
    logic [15:0] thresh_neg_z;
    logic [5:0]  target_extent;
    logic [5:0]  launch_offset;
  } cfg_t;

  typedef enum logic [2:0] {
    REG_THRESH_NEG_X  = 3'd0,
    REG_THRESH_POS_X  = 3'd1,
    REG_THRESH_NEG_Y  = 3'd2,
    REG_THRESH_POS_Y  = 3'd3,
    REG_THRESH_NEG_Z  = 3'd4,
    REG_TARGET_EXTENT = 3'd5,
    REG_LAUNCH_OFFSET = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    DIR_NEG_X,
    DIR_POS_X,
    DIR_NEG_Y,
    DIR_POS_Y,
    DIR_NEG_Z,
    DIR_POS_Z
  } dir_t;

  localparam logic [15:0] RST_THRESH_NEG_X  = 16'd11374;
  localparam logic [15:0] RST_THRESH_POS_X  = 16'd22206;
  localparam logic [15:0] RST_THRESH_NEG_Y  = 16'd33038;
  localparam logic [15:0] RST_THRESH_POS_Y  = 16'd43871;
  localparam logic [15:0] RST_THRESH_NEG_Z  = 16'd54703;
  localparam logic [5:0]  RST_TARGET_EXTENT = 6'd48;
  localparam logic [5:0]  RST_LAUNCH_OFFSET = 6'd10;

  // First threshold that holds wins; thresholds need not rise.
  function automatic dir_t dir_of(input logic [15:0] dice, input cfg_t c);
    if (dice <= c.thresh_neg_x) return DIR_NEG_X;
    if (dice <= c.thresh_pos_x) return DIR_POS_X;
    if (dice <= c.thresh_neg_y) return DIR_NEG_Y;
    if (dice <= c.thresh_pos_y) return DIR_POS_Y;
    if (dice <= c.thresh_neg_z) return DIR_NEG_Z;
    return DIR_POS_Z;
  endfunction

endpackage

FILE: hdl/lagw_cfg_regs.sv
module lagw_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_wdata,
  output lagw_pkg::cfg_t      cfg
);

  lagw_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thresh_neg_x  <= lagw_pkg::RST_THRESH_NEG_X;
      cfg_r.thresh_pos_x  <= lagw_pkg::RST_THRESH_POS_X;
      cfg_r.thresh_neg_y  <= lagw_pkg::RST_THRESH_NEG_Y;
      cfg_r.thresh_pos_y  <= lagw_pkg::RST_THRESH_POS_Y;
      cfg_r.thresh_neg_z  <= lagw_pkg::RST_THRESH_NEG_Z;
      cfg_r.target_extent <= lagw_pkg::RST_TARGET_EXTENT;
      cfg_r.launch_offset <= lagw_pkg::RST_LAUNCH_OFFSET;
    end else if (cfg_we) begin
      unique case (lagw_pkg::reg_idx_t'(cfg_index))
        lagw_pkg::REG_THRESH_NEG_X:  cfg_r.thresh_neg_x  <= cfg_wdata;
        lagw_pkg::REG_THRESH_POS_X:  cfg_r.thresh_pos_x  <= cfg_wdata;
        lagw_pkg::REG_THRESH_NEG_Y:  cfg_r.thresh_neg_y  <= cfg_wdata;
        lagw_pkg::REG_THRESH_POS_Y:  cfg_r.thresh_pos_y  <= cfg_wdata;
        lagw_pkg::REG_THRESH_NEG_Z:  cfg_r.thresh_neg_z  <= cfg_wdata;
        lagw_pkg::REG_TARGET_EXTENT: cfg_r.target_extent <= cfg_wdata[5:0];
        lagw_pkg::REG_LAUNCH_OFFSET: cfg_r.launch_offset <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: hdl/lagw_occ_mem.sv
module lagw_occ_mem #(
  parameter int ROW_W = 64,
  parameter int AW    = 12
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [ROW_W-1:0] wdata,
  output logic [ROW_W-1:0] rdata
);

  logic [ROW_W-1:0] mem [2**AW];
  logic [ROW_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/lattice_aggregation_walk_step.sv
// Flow: an accepted walk step request passes S_MOVE, S_RD, S_CHK, S_WRITE (only when it
//   sticks) and S_OUT before out_valid rises; a request taken once the target extent is
//   reached goes straight to S_OUT. A new request is taken only once the last result is
//   loaded: the move, five row reads, the check, the row write-back through the single-port
//   occupancy memory and the result load; a stalled result holds off the next load.
// Reset: synchronous, active low; then a clearing pass of Y_CELLS*Z_CELLS rows
//   (rounded up to powers of two, 4096 rows at defaults) before in_ready rises.
module lattice_aggregation_walk_step #(
  parameter int X_CELLS = 64,
  parameter int Y_CELLS = 64,
  parameter int Z_CELLS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_dice,
  input  logic [5:0]  in_launch_y,
  input  logic [5:0]  in_launch_z,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_stuck,
  output logic [5:0]  out_cell_x,
  output logic [5:0]  out_cell_y,
  output logic [5:0]  out_cell_z,
  output logic [5:0]  out_extent,
  output logic        out_done_res,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int XW = $clog2(X_CELLS);
  localparam int YW = $clog2(Y_CELLS);
  localparam int ZW = $clog2(Z_CELLS);
  localparam int AW = YW + ZW;
  localparam int SW = ((XW > 6) ? XW : 6) + 1;

  // Row reads of one step: center row gives the x-1 and x+1 neighbours.
  localparam logic [2:0] RD_CTR  = 3'd0;
  localparam logic [2:0] RD_YM   = 3'd1;
  localparam logic [2:0] RD_YP   = 3'd2;
  localparam logic [2:0] RD_ZM   = 3'd3;
  localparam logic [2:0] RD_ZP   = 3'd4;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_MOVE,
    S_RD,
    S_CHK,
    S_WRITE,
    S_OUT
  } state_t;

  state_t          state_r;
  lagw_pkg::cfg_t  cfg;
  lagw_pkg::dir_t  dir_r;

  logic [AW-1:0]   clr_addr_r;
  logic [XW-1:0]   walker_x_r;
  logic [YW-1:0]   walker_y_r;
  logic [ZW-1:0]   walker_z_r;
  logic            active_r;
  logic [XW-1:0]   max_ext_r;
  logic            finished_r;
  logic [YW-1:0]   ly_r;
  logic [ZW-1:0]   lz_r;
  logic            force_r;
  logic            hit_r;
  logic            hit_nxt;
  logic [2:0]      rd_cnt_r;
  logic            chk_vld_r;
  logic [2:0]      chk_idx_r;
  logic [X_CELLS-1:0] row_r;
  logic            stuck_r;

  logic            out_valid_r;
  logic            out_stuck_r;
  logic [5:0]      out_cell_x_r;
  logic [5:0]      out_cell_y_r;
  logic [5:0]      out_cell_z_r;
  logic [5:0]      out_extent_r;
  logic            out_done_r;

  logic               mem_en;
  logic               mem_we;
  logic [AW-1:0]      mem_addr;
  logic [X_CELLS-1:0] mem_wdata;
  logic [X_CELLS-1:0] mem_rdata;

  logic [SW-1:0]   launch_sum;
  logic [XW-1:0]   launch_x;
  logic [XW-1:0]   base_x;
  logic [YW-1:0]   base_y;
  logic [ZW-1:0]   base_z;
  logic [XW-1:0]   move_x;
  logic [YW-1:0]   move_y;
  logic [ZW-1:0]   move_z;
  logic [YW-1:0]   ym;
  logic [YW-1:0]   yp;
  logic [ZW-1:0]   zm;
  logic [ZW-1:0]   zp;
  logic [XW-1:0]   new_max;

  // Remainder of a 6-bit value by restoring subtraction, six narrow steps.
  function automatic logic [YW-1:0] mod_y(input logic [5:0] v);
    int r;
    r = int'(v);
    for (int k = 5; k >= 0; k--) begin
      if (r >= (Y_CELLS << k)) r = r - (Y_CELLS << k);
    end
    return YW'(r);
  endfunction

  function automatic logic [ZW-1:0] mod_z(input logic [5:0] v);
    int r;
    r = int'(v);
    for (int k = 5; k >= 0; k--) begin
      if (r >= (Z_CELLS << k)) r = r - (Z_CELLS << k);
    end
    return ZW'(r);
  endfunction

  lagw_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lagw_occ_mem #(
    .ROW_W (X_CELLS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Launch x, clamped to 1 .. X_CELLS-2.
  always_comb begin
    launch_sum = SW'(max_ext_r) + SW'(cfg.launch_offset);
    if (launch_sum < SW'(1)) begin
      launch_x = XW'(1);
    end else if (launch_sum > SW'(X_CELLS - 2)) begin
      launch_x = XW'(X_CELLS - 2);
    end else begin
      launch_x = XW'(launch_sum);
    end
  end

  always_comb begin
    base_x = active_r ? walker_x_r : launch_x;
    base_y = active_r ? walker_y_r : ly_r;
    base_z = active_r ? walker_z_r : lz_r;
    move_x = base_x;
    move_y = base_y;
    move_z = base_z;
    case (dir_r)
      lagw_pkg::DIR_NEG_X: move_x = base_x - XW'(1);
      lagw_pkg::DIR_POS_X: move_x = base_x + XW'(1);
      lagw_pkg::DIR_NEG_Y:
        move_y = (base_y == '0) ? YW'(Y_CELLS - 1) : base_y - YW'(1);
      lagw_pkg::DIR_POS_Y:
        move_y = (base_y >= YW'(Y_CELLS - 1)) ? '0 : base_y + YW'(1);
      lagw_pkg::DIR_NEG_Z:
        move_z = (base_z == '0) ? ZW'(Z_CELLS - 1) : base_z - ZW'(1);
      default:
        move_z = (base_z >= ZW'(Z_CELLS - 1)) ? '0 : base_z + ZW'(1);
    endcase
  end

  // Wrapped neighbour rows of the current walker.
  always_comb begin
    ym = (walker_y_r == '0) ? YW'(Y_CELLS - 1) : walker_y_r - YW'(1);
    yp = (walker_y_r >= YW'(Y_CELLS - 1)) ? '0 : walker_y_r + YW'(1);
    zm = (walker_z_r == '0) ? ZW'(Z_CELLS - 1) : walker_z_r - ZW'(1);
    zp = (walker_z_r >= ZW'(Z_CELLS - 1)) ? '0 : walker_z_r + ZW'(1);
  end

  // Fold in the row that arrived this cycle.
  always_comb begin
    hit_nxt = hit_r;
    if (chk_vld_r) begin
      if (chk_idx_r == RD_CTR) begin
        hit_nxt = hit_r
                | ((walker_x_r != '0) && mem_rdata[walker_x_r - XW'(1)])
                | mem_rdata[walker_x_r + XW'(1)];
      end else begin
        hit_nxt = hit_r | mem_rdata[walker_x_r];
      end
    end
  end

  assign new_max = (walker_x_r > max_ext_r) ? walker_x_r : max_ext_r;

  always_comb begin
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = {walker_z_r, walker_y_r};
    mem_wdata = row_r | (X_CELLS'(1) << walker_x_r);
    unique case (state_r)
      S_CLR: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = clr_addr_r;
        mem_wdata = '0;
      end
      S_RD: begin
        mem_en = 1'b1;
        case (rd_cnt_r)
          RD_YM:   mem_addr = {walker_z_r, ym};
          RD_YP:   mem_addr = {walker_z_r, yp};
          RD_ZM:   mem_addr = {zm, walker_y_r};
          RD_ZP:   mem_addr = {zp, walker_y_r};
          default: mem_addr = {walker_z_r, walker_y_r};
        endcase
      end
      S_WRITE: begin
        mem_en = 1'b1;
        mem_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_addr_r   <= '0;
      walker_x_r   <= '0;
      walker_y_r   <= '0;
      walker_z_r   <= '0;
      active_r     <= 1'b0;
      max_ext_r    <= '0;
      finished_r   <= 1'b0;
      chk_vld_r    <= 1'b0;
      hit_r        <= 1'b0;
      force_r      <= 1'b0;
      stuck_r      <= 1'b0;
      rd_cnt_r     <= RD_CTR;
      out_valid_r  <= 1'b0;
    end else begin
      // S_OUT reloads the result register itself
      if (out_valid_r && out_ready && (state_r != S_OUT)) out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLR: begin
          clr_addr_r <= clr_addr_r + AW'(1);
          if (&clr_addr_r) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            if (finished_r) begin
              stuck_r <= 1'b0;
              state_r <= S_OUT;
            end else begin
              dir_r     <= lagw_pkg::dir_of(in_dice, cfg);
              ly_r      <= mod_y(in_launch_y);
              lz_r      <= mod_z(in_launch_z);
              hit_r     <= 1'b0;
              chk_vld_r <= 1'b0;
              rd_cnt_r  <= RD_CTR;
              state_r   <= S_MOVE;
            end
          end
        end
        S_MOVE: begin
          active_r <= 1'b1;
          force_r  <= (move_x == '0);
          if (move_x == XW'(X_CELLS - 1)) begin
            // far edge: relaunch with this request's y and z
            walker_x_r <= launch_x;
            walker_y_r <= ly_r;
            walker_z_r <= lz_r;
          end else begin
            walker_x_r <= move_x;
            walker_y_r <= move_y;
            walker_z_r <= move_z;
          end
          state_r <= S_RD;
        end
        S_RD: begin
          hit_r     <= hit_nxt;
          if (chk_vld_r && chk_idx_r == RD_CTR) row_r <= mem_rdata;
          chk_vld_r <= 1'b1;
          chk_idx_r <= rd_cnt_r;
          rd_cnt_r  <= rd_cnt_r + 3'd1;
          if (rd_cnt_r == RD_ZP) state_r <= S_CHK;
        end
        S_CHK: begin
          chk_vld_r <= 1'b0;
          if (force_r || hit_nxt) begin
            state_r <= S_WRITE;
          end else begin
            stuck_r <= 1'b0;
            state_r <= S_OUT;
          end
        end
        S_WRITE: begin
          stuck_r   <= 1'b1;
          active_r  <= 1'b0;
          max_ext_r <= new_max;
          if (SW'(new_max) >= SW'(cfg.target_extent)) finished_r <= 1'b1;
          state_r   <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_stuck_r  <= stuck_r;
            out_cell_x_r <= 6'(walker_x_r);
            out_cell_y_r <= 6'(walker_y_r);
            out_cell_z_r <= 6'(walker_z_r);
            out_extent_r <= 6'(max_ext_r);
            out_done_r   <= finished_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_stuck    = out_stuck_r;
  assign out_cell_x   = out_cell_x_r;
  assign out_cell_y   = out_cell_y_r;
  assign out_cell_z   = out_cell_z_r;
  assign out_extent   = out_extent_r;
  assign out_done_res = out_done_r;

endmodule

FILE: hdl/lagw_checker.sv
`include "lattice_aggregation_walk_step_macros.svh"

module lagw_checker #(
  parameter int X_CELLS = 64
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [15:0] in_dice,
  input logic [5:0]  in_launch_y,
  input logic [5:0]  in_launch_z,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_stuck,
  input logic [5:0]  out_cell_x,
  input logic [5:0]  out_cell_y,
  input logic [5:0]  out_cell_z,
  input logic [5:0]  out_extent,
  input logic        out_done_res,
  input logic        cfg_we,
  input logic [2:0]  cfg_index,
  input logic [15:0] cfg_wdata
);

  logic        small_grid;
  logic        in_wait;
  logic        out_wait;
  logic [27:0] in_bus;
  logic [25:0] out_bus;
  logic [18:0] cfg_bus;

  assign small_grid = (X_CELLS <= 64);
  assign in_wait    = in_valid && !in_ready;
  assign out_wait   = out_valid && !out_ready;
  assign in_bus     = {in_dice, in_launch_y, in_launch_z};
  assign out_bus    = {out_stuck, out_cell_x, out_cell_y, out_cell_z, out_extent, out_done_res};
  assign cfg_bus    = {cfg_index, cfg_wdata};

  `LAGW_ASSERT_NEXT(a_out_hold, out_wait, out_valid && $stable(out_bus), "result changed while stalled")

  `LAGW_ASSERT_NEXT(a_in_hold, in_wait, in_valid && $stable(in_bus), "request changed while waiting")

  // one request in flight: ready drops right after an accept
  `LAGW_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second request taken while busy")

  // a stuck cell never lies beyond the reported extent (checked only when X_CELLS <= 64)
  `LAGW_ASSERT_NOW(a_stuck_in_extent, small_grid && out_valid && out_stuck, out_cell_x <= out_extent, "stuck cell beyond extent")

  `LAGW_ASSERT_NOW(a_cfg_idle, cfg_we, in_ready && !out_valid && !$isunknown(cfg_bus), "config write while busy")

endmodule

bind lattice_aggregation_walk_step lagw_checker #(.X_CELLS(X_CELLS)) u_lagw_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_dice      (in_dice),
  .in_launch_y  (in_launch_y),
  .in_launch_z  (in_launch_z),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_stuck    (out_stuck),
  .out_cell_x   (out_cell_x),
  .out_cell_y   (out_cell_y),
  .out_cell_z   (out_cell_z),
  .out_extent   (out_extent),
  .out_done_res (out_done_res),
  .cfg_we       (cfg_we),
  .cfg_index    (cfg_index),
  .cfg_wdata    (cfg_wdata)
);
